FILE: rtl/core/lvlm_pkg.sv
package lvlm_pkg;

	localparam int FRAC_BITS = 8;
	localparam int LEVELS = 8;
	localparam int SAMPLE_W = 10;
	localparam int SMOOTH_W = SAMPLE_W + FRAC_BITS;
	localparam int LEVEL_W = 4;
	localparam int MASK_W = 8;
	localparam int FACTOR_W = 9;
	localparam int HYST_W = 16;
	localparam int DIV_STEPS = SAMPLE_W;
	localparam int CNT_W = 4;

	localparam logic [2:0] REG_RISE = 3'd0;
	localparam logic [2:0] REG_FALL = 3'd1;
	localparam logic [2:0] REG_HYST = 3'd2;
	localparam logic [2:0] REG_STEP = 3'd3;
	localparam logic [2:0] REG_MIN = 3'd4;
	localparam logic [2:0] REG_MAX = 3'd5;

	localparam logic [FACTOR_W-1:0] RISE_RST = 9'd218;
	localparam logic [FACTOR_W-1:0] FALL_RST = 9'd77;
	localparam logic [HYST_W-1:0] HYST_RST = 16'd768;
	localparam logic [SAMPLE_W-1:0] STEP_RST = 10'd12;
	localparam logic [SAMPLE_W-1:0] MIN_RST = 10'd0;
	localparam logic [SAMPLE_W-1:0] MAX_RST = 10'd100;

	typedef struct packed {
		logic [FACTOR_W-1:0] gain_rise;
		logic [FACTOR_W-1:0] gain_fall;
		logic [HYST_W-1:0] hysteresis_band;
		logic [SAMPLE_W-1:0] step_size;
		logic [SAMPLE_W-1:0] window_min;
		logic [SAMPLE_W-1:0] window_max;
	} lvlm_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_BAND,
		ST_DIV,
		ST_FINISH
	} lvlm_state_t;

	typedef struct packed {
		logic load;
		logic smooth;
		logic band;
		logic div_step;
		logic finish;
	} lvlm_cmd_t;

	typedef struct packed {
		logic need_div;
	} lvlm_stat_t;

endpackage

FILE: rtl/core/lvlm_regs.sv
module lvlm_regs
	import lvlm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output lvlm_cfg_t   cfg
);

	lvlm_cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_rise <= RISE_RST;
			cfg_q.gain_fall <= FALL_RST;
			cfg_q.hysteresis_band <= HYST_RST;
			cfg_q.step_size <= STEP_RST;
			cfg_q.window_min <= MIN_RST;
			cfg_q.window_max <= MAX_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RISE: cfg_q.gain_rise <= pwdata[FACTOR_W-1:0];
				REG_FALL: cfg_q.gain_fall <= pwdata[FACTOR_W-1:0];
				REG_HYST: cfg_q.hysteresis_band <= pwdata[HYST_W-1:0];
				REG_STEP: cfg_q.step_size <= pwdata[SAMPLE_W-1:0];
				REG_MIN: cfg_q.window_min <= pwdata[SAMPLE_W-1:0];
				REG_MAX: cfg_q.window_max <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RISE: prdata = {23'd0, cfg_q.gain_rise};
			REG_FALL: prdata = {23'd0, cfg_q.gain_fall};
			REG_HYST: prdata = {16'd0, cfg_q.hysteresis_band};
			REG_STEP: prdata = {22'd0, cfg_q.step_size};
			REG_MIN: prdata = {22'd0, cfg_q.window_min};
			REG_MAX: prdata = {22'd0, cfg_q.window_max};
			default: prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/core/lvlm_ctrl.sv
module lvlm_ctrl
	import lvlm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       m_tready,
	input  lvlm_stat_t stat,
	output lvlm_cmd_t  cmd,
	output logic       s_tready,
	output logic       m_tvalid
);

	lvlm_state_t state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;
	logic in_fire;

	assign out_free = !out_valid_q || m_tready;
	assign in_fire = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_SMOOTH;
			ST_SMOOTH: state_nxt = ST_BAND;
			ST_BAND: state_nxt = stat.need_div ? ST_DIV : ST_FINISH;
			ST_DIV: if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_FINISH;
			ST_FINISH: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SMOOTH: cmd.smooth = 1'b1;
			ST_BAND: cmd.band = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_FINISH: cmd.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.band)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_SMOOTH)
		else $error("accepted item did not start smoothing");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken result");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("divider ran past its step count");

endmodule

FILE: rtl/core/lvlm_dp.sv
module lvlm_dp
	import lvlm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lvlm_cfg_t           cfg,
	input  lvlm_cmd_t           cmd,
	input  logic [SAMPLE_W-1:0] sample,
	output lvlm_stat_t          stat,
	output logic [LEVEL_W-1:0]  bar_level,
	output logic [MASK_W-1:0]   lit_mask,
	output logic [SMOOTH_W-1:0] smoothed_value
);

	logic [SAMPLE_W-1:0] sample_q;
	logic [SMOOTH_W-1:0] smoothed_q;
	logic [LEVEL_W-1:0] level_q;

	// smoothing
	logic [SMOOTH_W-1:0] target;
	logic signed [SMOOTH_W:0] diff;
	logic signed [FACTOR_W:0] fac_s;
	logic signed [SMOOTH_W+FACTOR_W+1:0] prod;
	logic signed [SMOOTH_W+3:0] sum;
	logic [SMOOTH_W-1:0] s_new;

	assign target = {sample_q, {FRAC_BITS{1'b0}}};
	assign diff = $signed({1'b0, target}) - $signed({1'b0, smoothed_q});
	assign fac_s = $signed({1'b0, (target > smoothed_q) ? cfg.gain_rise : cfg.gain_fall});
	assign prod = fac_s * diff;
	// floor of product / 256 is the arithmetic shift
	assign sum = $signed({4'd0, smoothed_q})
		+ (SMOOTH_W + 4)'(prod >>> 8);

	always_comb begin
		if (sum < 0)
			s_new = '0;
		else if (sum > $signed({4'd0, {SMOOTH_W{1'b1}}}))
			s_new = '1;
		else
			s_new = sum[SMOOTH_W-1:0];
	end

	// window clamp, max applied last, then offset
	logic [SMOOTH_W-1:0] lo, hi, v_lo, v_cl;
	logic signed [SMOOTH_W:0] v;

	assign lo = {cfg.window_min, {FRAC_BITS{1'b0}}};
	assign hi = {cfg.window_max, {FRAC_BITS{1'b0}}};
	assign v_lo = (smoothed_q < lo) ? lo : smoothed_q;
	assign v_cl = (v_lo > hi) ? hi : v_lo;
	assign v = $signed({1'b0, v_cl}) - $signed({1'b0, lo});

	// hysteresis band, compared in 24-bit signed
	logic [SAMPLE_W-1:0] step_eff;
	logic [13:0] lvl_prod, up_prod;
	logic signed [23:0] vx, hx, low_b, up_b;
	logic outside;

	assign step_eff = (cfg.step_size == '0) ? SAMPLE_W'(1) : cfg.step_size;
	assign lvl_prod = {10'd0, level_q} * {4'd0, step_eff};
	assign up_prod = lvl_prod + {4'd0, step_eff};
	assign vx = 24'(v);
	assign hx = $signed({8'd0, cfg.hysteresis_band});
	assign low_b = $signed({2'd0, lvl_prod, {FRAC_BITS{1'b0}}});
	assign up_b = $signed({2'd0, up_prod, {FRAC_BITS{1'b0}}});
	assign outside = (vx + hx < low_b) || (vx > up_b + hx);
	assign stat.need_div = outside && !v[SMOOTH_W];

	// serial restoring divider: (v >> FRAC_BITS) / step
	logic [SAMPLE_W-1:0] quo_q, dvsr_q, pend_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W:0] rem_sh;
	logic used_div_q;
	logic [LEVEL_W-1:0] pend_lvl_q;

	// remainder stays below the divisor, so it fits the sample width
	assign rem_sh = {rem_q, quo_q[SAMPLE_W-1]};
	assign pend_q = quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load)
			sample_q <= sample;
		if (cmd.band) begin
			rem_q <= '0;
			quo_q <= v[SMOOTH_W-1:FRAC_BITS];
			dvsr_q <= step_eff;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, dvsr_q}) begin
				rem_q <= SAMPLE_W'(rem_sh - {1'b0, dvsr_q});
				quo_q <= {quo_q[SAMPLE_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[SAMPLE_W-1:0];
				quo_q <= {quo_q[SAMPLE_W-2:0], 1'b0};
			end
		end
	end

	// level resolve and output register
	logic [LEVEL_W-1:0] new_lvl;
	logic [MASK_W-1:0] mask;
	logic [LEVEL_W-1:0] out_lvl_q;
	logic [MASK_W-1:0] out_mask_q;
	logic [SMOOTH_W-1:0] out_s_q;

	always_comb begin
		if (!used_div_q)
			new_lvl = pend_lvl_q;
		else if (pend_q > SAMPLE_W'(LEVELS))
			new_lvl = LEVEL_W'(LEVELS);
		else
			new_lvl = pend_q[LEVEL_W-1:0];
		for (int i = 0; i < MASK_W; i++)
			mask[i] = new_lvl > LEVEL_W'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			level_q <= '0;
			used_div_q <= 1'b0;
			pend_lvl_q <= '0;
		end else begin
			if (cmd.smooth)
				smoothed_q <= s_new;
			if (cmd.band) begin
				used_div_q <= stat.need_div;
				pend_lvl_q <= outside ? '0 : level_q;
			end
			if (cmd.finish)
				level_q <= new_lvl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_lvl_q <= new_lvl;
			out_mask_q <= mask;
			out_s_q <= smoothed_q;
		end
	end

	assign bar_level = out_lvl_q;
	assign lit_mask = out_mask_q;
	assign smoothed_value = out_s_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_W'(LEVELS))
		else $error("bar level beyond level count");

endmodule

FILE: rtl/core/level_meter_attack_release_hysteresis_top.sv
// Bar-graph level meter: attack/release smoothing, window clamp, hysteresis.
// Input stream s_*: one 10-bit sample per item. Output stream m_*: one result
// per input item with bar level, lit-segment mask and the Q10.8 smoothed value.
// APB port: six registers at byte address 4*i (rise, fall, hysteresis, step,
// min, max); pready is tied high, reads return the register contents.
// m_tvalid rises after the smooth, band and finish steps when the level stays
// inside its band; when a new level is computed, the one-bit-per-cycle divider
// by step_size runs between the band and finish steps.
// s_tready is high only while no item is in work, so a new item is taken only
// after the last one has left the finish step.
// The result sits in an output register, so a new item is accepted while it
// waits; if m_tready stays low the next item stops at its final step until
// the register frees up.
// Reset (arst_n low) clears the smoothed value and the level to zero, loads
// the register defaults and drops m_tvalid.
module level_meter_attack_release_hysteresis_top
	import lvlm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] bar_level, [11:4] lit_mask, [29:12] smoothed_value
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lvlm_cfg_t cfg;
	lvlm_cmd_t cmd;
	lvlm_stat_t stat;
	logic [LEVEL_W-1:0] bar_level;
	logic [MASK_W-1:0] lit_mask;
	logic [SMOOTH_W-1:0] smoothed_value;

	lvlm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accept, smooth, band test, optional divide, publish
	lvlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	lvlm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sample         (s_tdata[SAMPLE_W-1:0]),
		.stat           (stat),
		.bar_level      (bar_level),
		.lit_mask       (lit_mask),
		.smoothed_value (smoothed_value)
	);

	assign m_tdata = {2'b00, smoothed_value, lit_mask, bar_level};

endmodule
